// ===== hdl/round_robin_time_slice_scheduler_macros.svh =====
// Assertion helpers for the scheduler.
// Each macro expands to one labelled concurrent assertion on clk, off while in reset.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // Default ring size, quantum after reset and slice count ceiling
    localparam int unsigned DEFAULT_RING_DEPTH = 16;
    localparam logic [7:0]  QUANTUM_RESET      = 8'd4;
    localparam logic [7:0]  SLICE_MAX          = 8'd255;

    // Operation codes
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_ZERO     = 3'd2,
        ST_IDLE     = 3'd3,
        ST_RAN      = 3'd4,
        ST_PREEMPT  = 3'd5,
        ST_DONE     = 3'd6
    } status_t;

    // Request payload
    typedef struct packed {
        logic        operation;
        logic [7:0]  job_id;
        logic [15:0] burst_ticks;
    } in_t;

    // Result payload
    typedef struct packed {
        status_t     status;
        logic [7:0]  running_id;
        logic [15:0] remaining_ticks;
        logic [7:0]  slice_used;
        logic [4:0]  jobs_waiting;
    } out_t;

    // One ring entry
    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] remaining;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/rrts_ring_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_ring_mem #(
    parameter int unsigned DEPTH  = rrts_pkg::DEFAULT_RING_DEPTH,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire rrts_pkg::entry_t    wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output rrts_pkg::entry_t         rd_data
);

    rrts_pkg::entry_t mem [DEPTH];
    rrts_pkg::entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/round_robin_time_slice_scheduler.sv =====
// Round-robin time-slice scheduler; job ring held in a synchronous RAM.
// Submit and idle tick: result registered the cycle after the request, next request then too unless out_stall holds it.
// Tick on a busy ring: head read in S_IDLE, then modify/write back in S_EXEC; requests are held off in S_EXEC.
// The RAM read latency plus the read-modify-write interlock on the head entry sets the tick rate.
// Reset (rst_n, async, active low): ring empty, pointers and slice count zero, quantum 4.
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_time_slice_scheduler_macros.svh"

module round_robin_time_slice_scheduler #(
    parameter int unsigned RING_DEPTH = rrts_pkg::DEFAULT_RING_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire rrts_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output rrts_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [7:0]     cfg_data
);

    localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
    localparam int unsigned OCC_W  = $clog2(RING_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [7:0]          slice_reg, slice_next;
    logic [7:0]          quantum_reg, quantum_next;
    logic                out_valid_reg, out_valid_next;
    rrts_pkg::out_t      out_data_reg, out_data_next;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    rrts_pkg::entry_t    mem_wr_data;
    logic                mem_rd_en;
    rrts_pkg::entry_t    mem_rd_data;

    logic                in_accept;
    logic                ring_full;
    logic                ring_empty;
    logic [15:0]         rem_dec;
    logic [7:0]          slice_inc;
    logic [7:0]          quantum_eff;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] n;
        if (p == ADDR_W'(RING_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    function automatic logic [4:0] to_jobs(input logic [OCC_W-1:0] o);
        logic [OCC_W+4:0] w;
        w = {5'b0, o};
        return w[4:0];
    endfunction

    rrts_ring_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    // Hold off requests while a tick is in flight or the result is stuck
    assign in_stall  = (state_reg == S_EXEC) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ring_full   = (occ_reg == OCC_W'(RING_DEPTH));
    assign ring_empty  = (occ_reg == '0);
    assign quantum_eff = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign rem_dec     = (mem_rd_data.remaining != 16'd0) ?
                         mem_rd_data.remaining - 16'd1 : 16'd0;
    assign slice_inc   = (slice_reg < rrts_pkg::SLICE_MAX) ? slice_reg + 8'd1 : slice_reg;

    // Work out next state, RAM access and result
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        slice_next     = slice_reg;
        quantum_next   = quantum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = tail_reg;
        mem_wr_data    = '{job_id: in_data.job_id, remaining: in_data.burst_ticks};
        mem_rd_en      = 1'b0;

        // drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            quantum_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.operation == rrts_pkg::OP_SUBMIT)
                    begin
                        out_data_next.running_id      = in_data.job_id;
                        out_data_next.remaining_ticks = 16'd0;
                        out_data_next.slice_used      = 8'd0;
                        if (ring_full)
                        begin
                            out_data_next.status = rrts_pkg::ST_FULL;
                        end
                        else if (in_data.burst_ticks == 16'd0)
                        begin
                            out_data_next.status = rrts_pkg::ST_ZERO;
                        end
                        else
                        begin
                            // append at the tail
                            mem_wr_en            = 1'b1;
                            tail_next            = ring_next(tail_reg);
                            occ_next             = occ_reg + 1'b1;
                            out_data_next.status = rrts_pkg::ST_ACCEPTED;
                        end
                        out_data_next.jobs_waiting = to_jobs(occ_next);
                        out_valid_next             = 1'b1;
                    end
                    else if (ring_empty)
                    begin
                        out_data_next.status          = rrts_pkg::ST_IDLE;
                        out_data_next.running_id      = 8'd0;
                        out_data_next.remaining_ticks = 16'd0;
                        out_data_next.slice_used      = 8'd0;
                        out_data_next.jobs_waiting    = 5'd0;
                        out_valid_next                = 1'b1;
                    end
                    else
                    begin
                        // fetch the head job
                        mem_rd_en  = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                out_data_next.running_id      = mem_rd_data.job_id;
                out_data_next.remaining_ticks = rem_dec;
                out_data_next.slice_used      = slice_inc;
                mem_wr_data = '{job_id: mem_rd_data.job_id, remaining: rem_dec};
                if (rem_dec == 16'd0)
                begin
                    // retire the job
                    head_next            = ring_next(head_reg);
                    occ_next             = occ_reg - 1'b1;
                    slice_next           = 8'd0;
                    out_data_next.status = rrts_pkg::ST_DONE;
                end
                else if (slice_inc >= quantum_eff)
                begin
                    // rotate the job to the tail
                    mem_wr_en            = 1'b1;
                    mem_wr_addr          = tail_reg;
                    tail_next            = ring_next(tail_reg);
                    head_next            = ring_next(head_reg);
                    slice_next           = 8'd0;
                    out_data_next.status = rrts_pkg::ST_PREEMPT;
                end
                else
                begin
                    // write back the charged work
                    mem_wr_en            = 1'b1;
                    mem_wr_addr          = head_reg;
                    slice_next           = slice_inc;
                    out_data_next.status = rrts_pkg::ST_RAN;
                end
                out_data_next.jobs_waiting = to_jobs(occ_next);
                out_valid_next             = 1'b1;
                state_next                 = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            slice_reg     <= '0;
            quantum_reg   <= rrts_pkg::QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            slice_reg     <= slice_next;
            quantum_reg   <= quantum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `RRTS_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= OCC_W'(RING_DEPTH), "occupancy beyond ring depth")
    `RRTS_ASSERT_SAME(a_empty_ptrs, occ_reg == '0, head_reg == tail_reg, "empty ring with head != tail")
    `RRTS_ASSERT_SAME(a_exec_out_free, state_reg == S_EXEC, !out_valid_reg, "result register busy during tick")
    `RRTS_ASSERT_NEXT(a_tick_fetch, in_accept && (in_data.operation == rrts_pkg::OP_TICK) && !ring_empty, (state_reg == S_EXEC) && !out_valid_reg, "head fetch not followed by execute")

endmodule

`default_nettype wire

// ===== bench/schedule_checker.sv =====
`timescale 1ns / 1ps

module schedule_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  rrts_pkg::in_t   in_data,
    input  logic            out_valid,
    input  logic            out_stall,
    input  rrts_pkg::out_t  out_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    output int              mismatch_count,
    output int              results_owed
);

    localparam int SLOTS = rrts_pkg::DEFAULT_RING_DEPTH;

    // Shadow copy of the job ring and slice state
    logic [7:0]               job_ids  [SLOTS];
    logic [15:0]              job_left [SLOTS];
    logic [$clog2(SLOTS)-1:0] head_slot;
    logic [$clog2(SLOTS)-1:0] tail_slot;
    logic [4:0]               job_count;
    logic [7:0]               slice_ticks;
    logic [7:0]               quantum;

    rrts_pkg::out_t owed_results[$];

    // Apply one request to the shadow ring and work out its result
    task automatic advance_schedule(input rrts_pkg::in_t req, output rrts_pkg::out_t res);
        logic [7:0]  q;
        logic [7:0]  jid;
        logic [15:0] left;
        begin
            res = '0;
            if (req.operation == rrts_pkg::OP_SUBMIT)
            begin
                res.running_id = req.job_id;
                if (job_count >= SLOTS)
                    res.status = rrts_pkg::ST_FULL;
                else if (req.burst_ticks == 16'd0)
                    res.status = rrts_pkg::ST_ZERO;
                else
                begin
                    job_ids[tail_slot]  = req.job_id;
                    job_left[tail_slot] = req.burst_ticks;
                    tail_slot = tail_slot + 1'b1;
                    job_count = job_count + 1'b1;
                    res.status = rrts_pkg::ST_ACCEPTED;
                end
            end
            else if (job_count == 5'd0)
            begin
                res.status = rrts_pkg::ST_IDLE;
            end
            else
            begin
                // A zero quantum behaves as one tick per slice
                q    = (quantum == 8'd0) ? 8'd1 : quantum;
                jid  = job_ids[head_slot];
                left = job_left[head_slot];
                if (left != 16'd0)
                    left = left - 1'b1;
                job_left[head_slot] = left;
                if (slice_ticks != rrts_pkg::SLICE_MAX)
                    slice_ticks = slice_ticks + 1'b1;
                res.running_id      = jid;
                res.remaining_ticks = left;
                res.slice_used      = slice_ticks;
                // Completion takes precedence over the end of the slice
                if (left == 16'd0)
                begin
                    head_slot   = head_slot + 1'b1;
                    job_count   = job_count - 1'b1;
                    slice_ticks = 8'd0;
                    res.status  = rrts_pkg::ST_DONE;
                end
                else if (slice_ticks >= q)
                begin
                    job_ids[tail_slot]  = jid;
                    job_left[tail_slot] = left;
                    tail_slot   = tail_slot + 1'b1;
                    head_slot   = head_slot + 1'b1;
                    slice_ticks = 8'd0;
                    res.status  = rrts_pkg::ST_PREEMPT;
                end
                else
                begin
                    res.status = rrts_pkg::ST_RAN;
                end
            end
            res.jobs_waiting = job_count;
        end
    endtask

    // Track configuration, predict on each request, compare each result
    always @(posedge clk or negedge rst_n)
    begin : track
        rrts_pkg::out_t predicted;
        rrts_pkg::out_t wanted;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                job_ids[i]  = 8'd0;
                job_left[i] = 16'd0;
            end
            head_slot      = '0;
            tail_slot      = '0;
            job_count      = 5'd0;
            slice_ticks    = 8'd0;
            quantum        = rrts_pkg::QUANTUM_RESET;
            owed_results.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                quantum = cfg_data;
            if (in_valid && !in_stall)
            begin
                advance_schedule(in_data, predicted);
                owed_results.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result with no request outstanding: %p", out_data);
                    mismatch_count++;
                end
                else
                begin
                    wanted = owed_results.pop_front();
                    if (out_data.status !== wanted.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               wanted.status, out_data.status);
                        mismatch_count++;
                    end
                    if (out_data.running_id !== wanted.running_id)
                    begin
                        $error("running_id: expected %0d, got %0d",
                               wanted.running_id, out_data.running_id);
                        mismatch_count++;
                    end
                    if (out_data.remaining_ticks !== wanted.remaining_ticks)
                    begin
                        $error("remaining_ticks: expected %0d, got %0d",
                               wanted.remaining_ticks, out_data.remaining_ticks);
                        mismatch_count++;
                    end
                    if (out_data.slice_used !== wanted.slice_used)
                    begin
                        $error("slice_used: expected %0d, got %0d",
                               wanted.slice_used, out_data.slice_used);
                        mismatch_count++;
                    end
                    if (out_data.jobs_waiting !== wanted.jobs_waiting)
                    begin
                        $error("jobs_waiting: expected %0d, got %0d",
                               wanted.jobs_waiting, out_data.jobs_waiting);
                        mismatch_count++;
                    end
                end
            end
            results_owed = owed_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    rrts_pkg::in_t   in_data;
    logic            out_valid;
    logic            out_stall;
    rrts_pkg::out_t  out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [7:0]      cfg_data;

    int         mismatch_count;
    int         results_owed;
    logic       gaps_on;
    int         stall_left;

    round_robin_time_slice_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    schedule_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stall the result side in random bursts while gaps are enabled
    always @(posedge clk)
    begin
        if (!gaps_on)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(0, 9);
        end
    end

    function automatic rrts_pkg::in_t make_request(input logic op, input logic [7:0] id,
                                                   input logic [15:0] burst);
        rrts_pkg::in_t req;
        req.operation   = op;
        req.job_id      = id;
        req.burst_ticks = burst;
        return req;
    endfunction

    // Mostly short jobs so the ring keeps turning over; rare huge bursts
    function automatic rrts_pkg::in_t random_request(input int submit_pct);
        rrts_pkg::in_t req;
        req.operation = ($urandom_range(0, 99) < submit_pct) ? rrts_pkg::OP_SUBMIT
                                                             : rrts_pkg::OP_TICK;
        req.job_id    = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 199))
            0:       req.burst_ticks = 16'($urandom_range(0, 65535));
            1, 2, 3: req.burst_ticks = 16'd0;
            default: req.burst_ticks = 16'($urandom_range(1, 7));
        endcase
        return req;
    endfunction

    // Offer one request, with an optional gap first, and hold until taken
    task automatic send_request(input rrts_pkg::in_t req);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_quantum(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // End the run if nothing moves on any channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] phase_quantum [PHASES];
        int         submit_pct;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'd0;
        gaps_on   <= 1'b1;
        phase_quantum = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd6, 8'd2, 8'd4};
        phase_quantum[4] = 8'($urandom_range(1, 255));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick with junk in the ignored fields, then a zero burst
        send_request(make_request(rrts_pkg::OP_TICK, 8'h3C, 16'hC3A5));
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'hA5, 16'h0000));
        // Fill the ring: a job that never finishes, one that ends on its quantum
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'hFF, 16'hFFFF));
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'h00, 16'd4));
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'h5A, 16'd30));
        for (int n = 3; n < int'(rrts_pkg::DEFAULT_RING_DEPTH); n++)
            send_request(make_request(rrts_pkg::OP_SUBMIT, 8'($urandom_range(0, 255)),
                                      16'($urandom_range(1, 20))));
        // Reject on a full ring, also when the burst is zero as well
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'h77, 16'd5));
        send_request(make_request(rrts_pkg::OP_SUBMIT, 8'h78, 16'd0));
        // Rotate with the ring full, then complete exactly at the quantum
        repeat (8)
            send_request(make_request(rrts_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 65535))));

        // Lower the quantum below the ticks already used in the slice
        drain_results();
        write_quantum(8'd255);
        repeat (6)
            send_request(make_request(rrts_pkg::OP_TICK, 8'h00, 16'h0000));
        drain_results();
        write_quantum(8'd2);
        send_request(make_request(rrts_pkg::OP_TICK, 8'hFF, 16'hFFFF));

        // Random phases, each under its own quantum and load
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_quantum(phase_quantum[p]);
            gaps_on    <= (p != 5) && (p != PHASES - 1);
            submit_pct  = (p % 2 == 0) ? 45 : 22;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request(submit_pct));
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
